### sv/olst_pkg.sv
// Shared types and codes for the ordered list store.
// Used by olst_cell, olst_ctrl and ordered_list_store_core; depends on nothing.
`timescale 1ns / 1ps

package olst_pkg;

  // Request codes carried on the input word.
  typedef logic [1:0] op_t;
  localparam op_t OP_PUSH     = 2'd0;
  localparam op_t OP_REMOVE   = 2'd1;
  localparam op_t OP_READ_FWD = 2'd2;
  localparam op_t OP_READ_BWD = 2'd3;

  // Status codes carried on the result word.
  typedef logic [2:0] status_t;
  localparam status_t ST_ELEMENT   = 3'd0;
  localparam status_t ST_ACCEPTED  = 3'd1;
  localparam status_t ST_NOT_FOUND = 3'd2;
  localparam status_t ST_FULL      = 3'd3;
  localparam status_t ST_EMPTY     = 3'd4;

  // Width of the external value ports.
  localparam int PORT_W = 32;

  // Per-cell shift controls from the controller.
  typedef struct packed {
    logic shift_r;  // take the left neighbor (push at the front)
    logic shift_l;  // take the right neighbor (close a gap on removal)
  } cell_ctl_t;

endpackage

### sv/olst_cell.sv
// One storage cell of the ordered list store chain.
// Depends on olst_pkg for the cell control struct.
`timescale 1ns / 1ps

module olst_cell #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                   clk,
  input  olst_pkg::cell_ctl_t    ctl,
  input  logic [VALUE_WIDTH-1:0] left_data,
  input  logic [VALUE_WIDTH-1:0] right_data,
  input  logic [VALUE_WIDTH-1:0] key,
  output logic [VALUE_WIDTH-1:0] data,
  output logic                   match
);
  import olst_pkg::*;

  logic [VALUE_WIDTH-1:0] data_r;

  // The stored value moves right on a push and left when a gap is closed.
  always_ff @(posedge clk) begin
    if (ctl.shift_r) begin
      data_r <= left_data;
    end else if (ctl.shift_l) begin
      data_r <= right_data;
    end
  end

  // Each cell compares its own value against the removal key.
  assign data  = data_r;
  assign match = (data_r == key);

endmodule

### sv/olst_ctrl.sv
// Sequencer of the ordered list store: request decode, count, scan index
// and the registered result word. Depends on olst_pkg.
`timescale 1ns / 1ps

module olst_ctrl #(
  parameter int DEPTH       = 32,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  olst_pkg::op_t          in_op,
  input  logic signed [31:0]     in_value,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic signed [31:0]     out_value_out,
  output olst_pkg::status_t      out_status,
  output logic                   out_last,
  input  logic [VALUE_WIDTH-1:0] cell_data [DEPTH],
  input  logic [DEPTH-1:0]       cell_match,
  output olst_pkg::cell_ctl_t    cell_ctl [DEPTH],
  output logic [VALUE_WIDTH-1:0] push_data,
  output logic [VALUE_WIDTH-1:0] key
);
  import olst_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int IDX_W = $clog2(DEPTH);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_REMOVE = 2'd1;
  localparam logic [1:0] S_READ   = 2'd2;
  localparam logic [1:0] S_RESP   = 2'd3;

  logic [1:0]             state_r, state_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [CNT_W-1:0]       rem_r, rem_nxt;
  logic [IDX_W-1:0]       idx_r, idx_nxt;
  logic [VALUE_WIDTH-1:0] key_r, key_nxt;
  logic                   bwd_r, bwd_nxt;
  logic                   found_r, found_nxt;
  status_t                stat_r, stat_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [PORT_W-1:0]      out_value_r;
  status_t                out_status_r;
  logic                   out_last_r;

  logic                   in_acc;
  logic                   full;
  logic                   push_do;
  logic                   hit;
  logic                   out_free;
  logic                   load;
  logic [PORT_W-1:0]      ld_value;
  status_t                ld_status;
  logic                   ld_last;
  logic [VALUE_WIDTH-1:0] in_key;
  logic [VALUE_WIDTH-1:0] rd_data;

  // Input value is sign-extended or truncated to the storage width.
  assign in_key    = VALUE_WIDTH'(in_value);
  assign push_data = in_key;
  assign key       = key_r;

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && (state_r == S_IDLE);
  assign full     = (cnt_r == CNT_W'(DEPTH));
  assign push_do  = in_acc && (in_op == OP_PUSH) && !full;
  assign hit      = cell_match[idx_r];
  assign rd_data  = cell_data[idx_r];
  assign out_free = !out_valid_r || !out_stall;

  // Shift controls: all cells move right on a push; cells from the scan
  // index upward move left when the scanned cell matches the key.
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      cell_ctl[i].shift_r = push_do;
      cell_ctl[i].shift_l = (state_r == S_REMOVE) && hit && (IDX_W'(i) >= idx_r);
    end
  end

  // Next-state logic of the sequencer.
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    rem_nxt   = rem_r;
    idx_nxt   = idx_r;
    key_nxt   = key_r;
    bwd_nxt   = bwd_r;
    found_nxt = found_r;
    stat_nxt  = stat_r;
    load      = 1'b0;
    ld_value  = '0;
    ld_status = ST_ELEMENT;
    ld_last   = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          unique case (in_op) inside
            OP_PUSH: begin
              stat_nxt  = full ? ST_FULL : ST_ACCEPTED;
              if (!full) begin
                cnt_nxt = cnt_r + CNT_W'(1);
              end
              state_nxt = S_RESP;
            end
            OP_REMOVE: begin
              key_nxt   = in_key;
              found_nxt = 1'b0;
              idx_nxt   = '0;
              rem_nxt   = cnt_r;
              if (cnt_r == '0) begin
                stat_nxt  = ST_NOT_FOUND;
                state_nxt = S_RESP;
              end else begin
                state_nxt = S_REMOVE;
              end
            end
            OP_READ_FWD, OP_READ_BWD: begin
              bwd_nxt = (in_op == OP_READ_BWD);
              idx_nxt = (in_op == OP_READ_BWD) ? IDX_W'(cnt_r - CNT_W'(1)) : '0;
              rem_nxt = cnt_r;
              if (cnt_r == '0) begin
                stat_nxt  = ST_EMPTY;
                state_nxt = S_RESP;
              end else begin
                state_nxt = S_READ;
              end
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_REMOVE: begin
        // A match closes the gap and the same index is looked at again.
        if (hit) begin
          cnt_nxt   = cnt_r - CNT_W'(1);
          found_nxt = 1'b1;
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
        end
        rem_nxt = rem_r - CNT_W'(1);
        if (rem_r == CNT_W'(1)) begin
          stat_nxt  = (hit || found_r) ? ST_ACCEPTED : ST_NOT_FOUND;
          state_nxt = S_RESP;
        end
      end
      S_READ: begin
        if (out_free) begin
          load      = 1'b1;
          ld_value  = PORT_W'(rd_data);
          ld_status = ST_ELEMENT;
          ld_last   = (rem_r == CNT_W'(1));
          idx_nxt   = bwd_r ? idx_r - IDX_W'(1) : idx_r + IDX_W'(1);
          rem_nxt   = rem_r - CNT_W'(1);
          if (rem_r == CNT_W'(1)) begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_RESP: begin
        if (out_free) begin
          load      = 1'b1;
          ld_status = stat_r;
          ld_last   = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_valid_nxt = load ? 1'b1 : (out_stall ? out_valid_r : 1'b0);

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Working and result word registers.
  always_ff @(posedge clk) begin
    rem_r   <= rem_nxt;
    idx_r   <= idx_nxt;
    key_r   <= key_nxt;
    bwd_r   <= bwd_nxt;
    found_r <= found_nxt;
    stat_r  <= stat_nxt;
    if (load) begin
      out_value_r  <= ld_value;
      out_status_r <= ld_status;
      out_last_r   <= ld_last;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_value_out = out_value_r;
  assign out_status    = out_status_r;
  assign out_last      = out_last_r;

`ifndef SYNTHESIS
  // The count never exceeds the number of cells.
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(DEPTH))
    else $error("element count above depth");

  // A scan or read always has something left to visit.
  a_rem_live: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_REMOVE || state_r == S_READ) |-> (rem_r != '0))
    else $error("scan with nothing left");

  // An accepted push on a store with room grows the count by one.
  a_push_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    push_do |=> (cnt_r == $past(cnt_r) + CNT_W'(1)))
    else $error("push did not grow count");

  // A read never runs on an empty store.
  a_read_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_READ) |-> (cnt_r != '0))
    else $error("read of empty store");
`endif

endmodule

### sv/ordered_list_store_core.sv
// Ordered list store: a row of value cells under a small sequencer.
// Depends on olst_pkg, olst_cell and olst_ctrl.
//
// Usage: one request word enters on in_op/in_value under in_valid/in_stall.
// Push places a value at the front, remove deletes every copy of a value,
// read forward and read backward stream the stored values. Result words
// leave on out_value_out/out_status/out_last under out_valid/out_stall.
// Push and remove give one word (accepted, full or not found); a read gives
// one word per stored value with out_last on the final one, or one empty
// word when the store holds nothing.
// Timing: one request is worked at a time. A push gives its result word
// through the result state and then the output register. A removal walks
// the stored values once, one cell per cycle. A read passes through the
// read state and then loads one word per cycle into the output register
// while the output is not stalled. A new request is accepted in the cycle
// after the final word of the previous one is loaded. The cells shift in
// parallel, so the scan over the chain sets how long a removal takes.
// A stalled result word holds in the output register; a read run then pauses.
// Synchronous reset empties the store and drops any pending result word;
// cell contents are not cleared and are never seen before they are written.
`timescale 1ns / 1ps

module ordered_list_store_core #(
  parameter int DEPTH       = 32,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  olst_pkg::op_t       in_op,
  input  logic signed [31:0]  in_value,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [31:0]  out_value_out,
  output olst_pkg::status_t   out_status,
  output logic                out_last
);
  import olst_pkg::*;

  logic [VALUE_WIDTH-1:0] cell_data [DEPTH];
  logic [DEPTH-1:0]       cell_match;
  cell_ctl_t              cell_ctl [DEPTH];
  logic [VALUE_WIDTH-1:0] push_data;
  logic [VALUE_WIDTH-1:0] key;

  // Sequencer and result register.
  olst_ctrl #(
    .DEPTH       (DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_op         (in_op),
    .in_value      (in_value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_value_out (out_value_out),
    .out_status    (out_status),
    .out_last      (out_last),
    .cell_data     (cell_data),
    .cell_match    (cell_match),
    .cell_ctl      (cell_ctl),
    .push_data     (push_data),
    .key           (key)
  );

  // The chain: cell 0 is the front; inner cells link to both neighbors.
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [VALUE_WIDTH-1:0] left_d;
    logic [VALUE_WIDTH-1:0] right_d;

    if (g == 0) begin : g_front
      assign left_d = push_data;
    end else begin : g_inner_l
      assign left_d = cell_data[g-1];
    end

    if (g == DEPTH - 1) begin : g_back
      assign right_d = cell_data[g];
    end else begin : g_inner_r
      assign right_d = cell_data[g+1];
    end

    olst_cell #(
      .VALUE_WIDTH (VALUE_WIDTH)
    ) u_cell (
      .clk        (clk),
      .ctl        (cell_ctl[g]),
      .left_data  (left_d),
      .right_data (right_d),
      .key        (key),
      .data       (cell_data[g]),
      .match      (cell_match[g])
    );
  end

endmodule
